[hw/rtl/mma_pkg.sv]
// Shared types and constants for the multichannel moving average block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mma_pkg;

   localparam int CHAN_W           = 3;
   localparam int SAMPLE_W         = 16;
   localparam int DEFAULT_WINDOW   = 20;
   localparam int DEFAULT_CHANNELS = 8;
   localparam int DEFAULT_SUM_W    = SAMPLE_W + $clog2(DEFAULT_WINDOW);
   localparam int DEFAULT_CNT_W    = $clog2(DEFAULT_WINDOW + 1);

   typedef logic [CHAN_W-1:0]          chan_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // Status of the serial divider as seen by the controller.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

[hw/rtl/mma_req_if.sv]
// Request channel of the moving average block: channel number and sample.
// Depends on mma_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface mma_req_if;
   import mma_pkg::*;

   logic       valid;
   logic       ready;
   chan_type   channel;
   sample_type sample;

   modport source (output valid, output channel, output sample, input ready);
   modport sink   (input valid, input channel, input sample, output ready);
endinterface

`default_nettype wire

[hw/rtl/mma_rsp_if.sv]
// Response channel of the moving average block: channel number and mean.
// Depends on mma_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface mma_rsp_if;
   import mma_pkg::*;

   logic       valid;
   logic       ready;
   chan_type   out_channel;
   sample_type average;

   modport source (output valid, output out_channel, output average, input ready);
   modport sink   (input valid, input out_channel, input average, output ready);
endinterface

`default_nettype wire

[hw/rtl/multichannel_moving_average.sv]
// Top level of the multichannel boxcar moving average with warm-up.
// Depends on mma_pkg, mma_req_if, mma_rsp_if and mma_serial_div.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake        Payload
// req_ch    in         valid / ready    channel (3 b), sample (16 b signed)
// rsp_ch    out        valid / ready    out_channel (3 b), average (16 b signed)
//
// Each transfer in produces exactly one transfer out. A present channel passes
// through READ, UPDATE, DIVIDE and DONE before it answers; the bit-serial divider
// resolves one quotient bit per cycle. An absent channel goes from IDLE straight
// to DONE. A request is taken only in IDLE, after the previous result has entered
// the response register. Synchronous reset clears the per-channel sums, fill
// counts and ring pointers; the window memory is never cleared, since a slot is
// read only after it has been written. The response register lets the next
// request transfer in while a result waits on a stalled sink; that item then waits.

module multichannel_moving_average #(
   parameter int WINDOW   = mma_pkg::DEFAULT_WINDOW,
   parameter int CHANNELS = mma_pkg::DEFAULT_CHANNELS
) (
   input wire logic clock,
   input wire logic reset,
   mma_req_if.sink   req_ch,
   mma_rsp_if.source rsp_ch
);
   import mma_pkg::*;

   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int DEPTH  = CHANNELS * WINDOW;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_UPDATE,
      S_DIVIDE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Registered response and the item in flight.
   logic       rsp_valid_ff, rsp_valid_in;
   chan_type   rsp_chan_ff, rsp_chan_in;
   sample_type rsp_avg_ff, rsp_avg_in;
   chan_type   chan_ff, chan_in;
   sample_type sample_ff, sample_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   sample_type              avg_ff, avg_in;
   logic signed [SUM_W-1:0] part_ff, part_in;
   logic                    full_ff, full_in;

   // Per-channel state, cleared by reset.
   logic signed [SUM_W-1:0] sum_ff  [CHANNELS];
   logic [CNT_W-1:0]        fill_ff [CHANNELS];
   logic [SLOT_W-1:0]       slot_ff [CHANNELS];

   // Sample window, one ring of WINDOW entries per channel.
   logic [SAMPLE_W-1:0] win_mem [DEPTH];
   sample_type          rd_ff;

   logic [CIDX_W-1:0]       req_cidx, cidx;
   logic                    chan_ok;
   logic [ADDR_W-1:0]       req_addr;
   logic signed [SUM_W-1:0] new_sum;
   logic [CNT_W-1:0]        new_fill;
   logic [SLOT_W-1:0]       new_slot;
   logic                    div_start;
   div_status_type          div_stat;
   sample_type              div_quo;

   assign req_cidx = CIDX_W'(req_ch.channel);
   assign cidx     = CIDX_W'(chan_ff);
   assign chan_ok  = 32'(req_ch.channel) < CHANNELS;
   assign req_addr = ADDR_W'(32'(req_cidx) * WINDOW + 32'(slot_ff[req_cidx]));

   // Once the ring is full the oldest sample leaves the sum; part_ff already
   // holds the old sum plus the new sample, and any wrap there cancels out.
   assign new_sum  = full_ff ? (part_ff - SUM_W'(rd_ff)) : part_ff;
   assign new_fill = full_ff ? fill_ff[cidx] : (fill_ff[cidx] + 1'b1);
   assign new_slot = (slot_ff[cidx] == SLOT_W'(WINDOW - 1)) ? '0
                                                           : (slot_ff[cidx] + 1'b1);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_chan_in  = rsp_chan_ff;
      rsp_avg_in   = rsp_avg_ff;
      chan_in      = chan_ff;
      sample_in    = sample_ff;
      addr_in      = addr_ff;
      avg_in       = avg_ff;
      part_in      = part_ff;
      full_in      = full_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               chan_in   = req_ch.channel;
               sample_in = req_ch.sample;
               if (chan_ok) begin
                  addr_in  = req_addr;
                  state_in = S_READ;
               end else begin
                  // Absent channel: state is untouched and the mean reads zero.
                  avg_in   = '0;
                  state_in = S_DONE;
               end
            end
         end
         S_READ: begin
            part_in  = sum_ff[cidx] + SUM_W'(sample_ff);
            full_in  = fill_ff[cidx] == CNT_W'(WINDOW);
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            div_start = 1'b1;
            state_in  = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (div_stat.done) begin
               avg_in   = div_quo;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_chan_in  = chan_ff;
               rsp_avg_in   = avg_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_chan_ff <= rsp_chan_in;
      rsp_avg_ff  <= rsp_avg_in;
      chan_ff     <= chan_in;
      sample_ff   <= sample_in;
      addr_ff     <= addr_in;
      avg_ff      <= avg_in;
      part_ff     <= part_in;
      full_ff     <= full_in;
   end

   // The per-channel sum, count and pointer change once per item on a present
   // channel, when the old sample has come back from the window memory.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i]  <= '0;
            fill_ff[i] <= '0;
            slot_ff[i] <= '0;
         end
      end else if (state_ff == S_UPDATE) begin
         sum_ff[cidx]  <= new_sum;
         fill_ff[cidx] <= new_fill;
         slot_ff[cidx] <= new_slot;
      end
   end

   // The slot is read in one cycle and overwritten with the new sample in the next.
   always_ff @(posedge clock) begin
      if (state_ff == S_UPDATE) begin
         win_mem[addr_ff] <= sample_ff;
      end
      rd_ff <= win_mem[addr_ff];
   end

   mma_serial_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (new_sum),
      .divisor  (new_fill),
      .status   (div_stat),
      .quotient (div_quo)
   );

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_channel = rsp_chan_ff;
   assign rsp_ch.average     = rsp_avg_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response appeared outside the completion state");

   a_update_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |-> $past(state_ff == S_READ))
      else $error("window update without a memory read");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |-> (new_fill <= CNT_W'(WINDOW)) && (new_fill != '0))
      else $error("fill count out of range");

   a_divider_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE) |-> (div_stat.busy || div_stat.done))
      else $error("waiting on an idle divider");

endmodule

`default_nettype wire

[hw/rtl/mma_serial_div.sv]
// Bit-serial signed divider: one quotient bit per cycle, truncates toward zero.
// Depends on mma_pkg for the quotient type and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module mma_serial_div #(
   parameter int SUM_W = mma_pkg::DEFAULT_SUM_W,
   parameter int CNT_W = mma_pkg::DEFAULT_CNT_W
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [SUM_W-1:0]  dividend,
   input  wire logic [CNT_W-1:0]         divisor,
   output mma_pkg::div_status_type       status,
   output mma_pkg::sample_type           quotient
);
   import mma_pkg::*;

   localparam int CTR_W = $clog2(SUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CTR_W-1:0] ctr_ff, ctr_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] div_ff, div_in;
   logic             neg_ff, neg_in;
   logic [CNT_W:0]   trial;
   logic             fits;

   // The dividend register shifts out its top bit each step while the
   // quotient bits shift in at the bottom.
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ctr_in  = ctr_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         ctr_in  = CTR_W'(SUM_W);
         quo_in  = dividend[SUM_W-1] ? (-dividend) : dividend;
         rem_in  = '0;
         div_in  = divisor;
         neg_in  = dividend[SUM_W-1];
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUM_W-2:0], fits};
         rem_in = fits ? CNT_W'(trial - {1'b0, div_ff}) : CNT_W'(trial);
         ctr_in = ctr_ff - 1'b1;
         if (ctr_ff == CTR_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ctr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         ctr_ff  <= ctr_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = SAMPLE_W'(neg_ff ? (-quo_ff) : quo_ff);

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider finished without running");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      !(start && busy_ff))
      else $error("divider started while busy");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider did not begin after start");

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the multichannel moving average block.
// Depends on mma_pkg, mma_req_if, mma_rsp_if and the block's RTL.
`timescale 1ns / 1ps

module testbench;
   import mma_pkg::*;

   localparam int WIN       = DEFAULT_WINDOW;
   localparam int CHANS     = DEFAULT_CHANNELS;
   localparam int HOLD_LEN  = 300;
   localparam int DRAIN_MAX = 5000;
   localparam int SETTLE    = 60;

   // Traffic phases: which side idles, and how often.
   typedef enum logic [1:0] {
      PHASE_SLOW_SINK,
      PHASE_SLOW_SOURCE,
      PHASE_NO_IDLE
   } traffic_phase_type;

   typedef struct {
      chan_type   channel;
      sample_type sample;
   } sample_item_type;

   typedef struct {
      chan_type   channel;
      sample_type average;
   } average_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mma_req_if req_ch ();
   mma_rsp_if rsp_ch ();

   multichannel_moving_average #(
      .WINDOW   (WIN),
      .CHANNELS (CHANS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // Samples waiting to be offered, and the averages still owed by the block.
   sample_item_type   sample_queue[$];
   average_item_type  expected_averages[$];
   traffic_phase_type phase = PHASE_SLOW_SINK;

   int items_total    = 0;
   int accepted_count = 0;
   int error_count    = 0;
   logic req_taken    = 1'b0;

   // Private copy of the per-channel averaging state.
   sample_type ring_mem[CHANS][WIN];
   int         chan_sum[CHANS];
   int         chan_fill[CHANS];
   int         chan_slot[CHANS];

   average_item_type got_avg;

   // Idle percentage for each side in the current phase.
   function automatic int idle_percent(traffic_phase_type ph, bit sender);
      case (ph)
         PHASE_SLOW_SINK:   return sender ? 13 : 54;
         PHASE_SLOW_SOURCE: return sender ? 54 : 13;
         default:           return 0;
      endcase
   endfunction

   // Stores the sample into the channel's ring, drops the oldest one once the
   // window is full, and returns the mean over the samples actually held.
   function automatic average_item_type predict_average(chan_type ch, sample_type s);
      average_item_type res;
      int c;
      c = int'(ch);
      res.channel = ch;
      res.average = '0;
      if (c < CHANS) begin
         if (chan_fill[c] >= WIN)
            chan_sum[c] -= int'(ring_mem[c][chan_slot[c]]);
         else
            chan_fill[c]++;
         ring_mem[c][chan_slot[c]] = s;
         chan_sum[c] += int'(s);
         chan_slot[c] = (chan_slot[c] + 1 >= WIN) ? 0 : chan_slot[c] + 1;
         // Integer division in SystemVerilog truncates toward zero.
         res.average = sample_type'(chan_sum[c] / chan_fill[c]);
      end
      return res;
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(9))
         0:       return sample_type'(16'sh7FFF);
         1:       return sample_type'(16'sh8000);
         2:       return sample_type'($urandom_range(20)) - sample_type'(10);
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic queue_sample(int ch, sample_type s);
      sample_item_type it;
      it.channel = chan_type'(ch);
      it.sample  = s;
      sample_queue.push_back(it);
      items_total++;
   endtask

   // Mostly scattered channels, with occasional long runs on one channel so
   // that windows fill completely with extreme or repeated values and wrap.
   task automatic queue_random(int count);
      int n;
      int run_len;
      int run_ch;
      sample_type run_val;
      n = 0;
      while (n < count) begin
         if ($urandom_range(19) == 0) begin
            run_ch  = $urandom_range(CHANS - 1);
            run_val = pick_sample();
            run_len = WIN + $urandom_range(6);
            repeat (run_len) begin
               queue_sample(run_ch, ($urandom_range(3) == 0) ? pick_sample() : run_val);
               n++;
            end
         end else begin
            queue_sample($urandom_range(7), pick_sample());
            n++;
         end
      end
   endtask

   // Prediction and checking share one process, so the expected queue is
   // always updated before a response from the same edge is compared.
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_ch.valid && req_ch.ready;
         if (req_taken) begin
            expected_averages.push_back(predict_average(req_ch.channel, req_ch.sample));
            accepted_count++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_averages.size() == 0) begin
               $display("%0t: unexpected response, actual channel %0d average %0d",
                        $time, rsp_ch.out_channel, rsp_ch.average);
               error_count++;
            end else begin
               got_avg = expected_averages.pop_front();
               if (rsp_ch.out_channel !== got_avg.channel) begin
                  $display("%0t: out_channel mismatch, expected %0d actual %0d",
                           $time, got_avg.channel, rsp_ch.out_channel);
                  error_count++;
               end
               if (rsp_ch.average !== got_avg.average) begin
                  $display("%0t: average mismatch on channel %0d, expected %0d actual %0d",
                           $time, got_avg.channel, got_avg.average, rsp_ch.average);
                  error_count++;
               end
            end
         end
      end
   end

   // Request driver: a new sample is offered only once the previous one has
   // been transferred, and valid is written at most once per falling edge.
   always @(negedge clock) begin
      sample_item_type it;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (sample_queue.size() != 0 && $urandom_range(99) >= idle_percent(phase, 1'b1)) begin
            it = sample_queue.pop_front();
            req_ch.valid   <= 1'b1;
            req_ch.channel <= it.channel;
            req_ch.sample  <= it.sample;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response sink. At the start of the phase without idling it holds off
   // for a long stretch, so the block backs up and stalls its input.
   int   hold_left = 0;
   logic hold_done = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (phase == PHASE_NO_IDLE && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_LEN - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= idle_percent(phase, 1'b0));
      end
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.channel = '0;
      req_ch.sample  = '0;
      rsp_ch.ready   = 1'b0;
   end

   initial begin
      int waited;
      foreach (chan_sum[c]) begin
         chan_sum[c]  = 0;
         chan_fill[c] = 0;
         chan_slot[c] = 0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      @(posedge clock);
      // Directed part: extremes on the edge channels, warm-up means over
      // fewer samples than the window, and truncation of negative quotients.
      queue_sample(0, 16'sh7FFF);
      queue_sample(0, 16'sh8000);
      queue_sample(0, -16'sd1);
      queue_sample(0, 16'sd1);
      queue_sample(7, 16'sh8000);
      queue_sample(7, 16'sh8000);
      queue_sample(7, 16'sh7FFF);
      queue_sample(5, -16'sd1);
      queue_sample(5, -16'sd2);
      queue_sample(6, 16'sd3);
      queue_sample(6, -16'sd7);
      queue_sample(6, 16'sd0);
      queue_sample(1, 16'sh5555);
      queue_sample(2, 16'shAAAA);
      queue_sample(3, 16'sd0);
      queue_sample(4, 16'sh7FFF);
      queue_sample(4, 16'sh7FFF);
      queue_sample(4, 16'sh7FFE);
      queue_random(180);
      while (sample_queue.size() != 0) @(negedge clock);

      @(posedge clock);
      phase = PHASE_SLOW_SOURCE;
      queue_random(180);
      while (sample_queue.size() != 0) @(negedge clock);

      @(posedge clock);
      phase = PHASE_NO_IDLE;
      queue_random(190);

      // Let every sample be transferred, then wait for the remaining averages.
      while (accepted_count != items_total) @(negedge clock);
      waited = 0;
      while (expected_averages.size() != 0 && waited < DRAIN_MAX) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE) @(negedge clock);
      if (expected_averages.size() != 0) begin
         $display("%0t: %0d expected averages never arrived",
                  $time, expected_averages.size());
         error_count++;
      end

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
